>>> rtl/core/ryuv_pkg.sv
// ----------------------------------------------------------------------------
// ryuv_pkg: shared types, constants and tables
// Holds the command/status structs, register indexes, coefficient table and
// the gamma tables built at elaboration time.
// ----------------------------------------------------------------------------
package ryuv_pkg;

    localparam int CMP_W   = 17;   // width of size compares, covers every legal max
    localparam int PIX_W   = 24;
    localparam int ACC_W   = 30;
    localparam int SUM_W   = 11;   // component sum at 4x scale, 0..1020
    localparam int LIN_W   = 12;
    localparam int GAM_W   = 9;
    localparam int IDX_W   = 4;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 15;

    localparam logic [CFGI_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFGI_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFGI_W-1:0] REG_PLAIN_MODE   = 2'd2;

    // Multiply step indexes: luma, then U, then V, three terms each
    localparam logic [IDX_W-1:0] STEP_LUMA_LAST = 4'd2;
    localparam logic [IDX_W-1:0] STEP_U_FIRST   = 4'd3;
    localparam logic [IDX_W-1:0] STEP_V_FIRST   = 4'd6;
    localparam logic [IDX_W-1:0] STEP_LAST      = 4'd8;
    localparam logic [1:0]       COMP_LAST      = 2'd2;

    typedef struct packed {
        logic             accept;
        logic             mul_en;
        logic [IDX_W-1:0] mul_idx;
        logic             rd_prev;
        logic             tr_load;
        logic             tl_load;
        logic             lin_en;
        logic             interp_en;
        logic [1:0]       comp;
        logic             cap_luma;
        logic             cap_u;
        logic             load_out;
    } ryuv_cmd_t;

    typedef struct packed {
        logic chroma;
        logic out_free;
    } ryuv_stat_t;

    function automatic logic signed [17:0] coef_of(input logic [IDX_W-1:0] idx);
        logic signed [17:0] c;
        case (idx)
            4'd0:    c = 18'sd16839;
            4'd1:    c = 18'sd33059;
            4'd2:    c = 18'sd6420;
            4'd3:    c = -18'sd9719;
            4'd4:    c = -18'sd19081;
            4'd5:    c = 18'sd28800;
            4'd6:    c = 18'sd28800;
            4'd7:    c = -18'sd24116;
            4'd8:    c = -18'sd4684;
            default: c = 18'sd0;
        endcase
        return c;
    endfunction

    function automatic logic [127:0] pow_of(input logic [127:0] b, input int n);
        logic [127:0] r;
        r = 128'd1;
        for (int i = 0; i < n; i++) r = r * b;
        return r;
    endfunction

    // round(4095*(v/255)^0.8) by exact compare of integer powers
    function automatic logic [LIN_W*256-1:0] build_lin();
        logic [LIN_W*256-1:0] t;
        logic [127:0] rhs, lhs;
        int lo, hi, mid;
        t = '0;
        for (int v = 0; v < 256; v++)
        begin
            rhs = pow_of(128'd8190, 5) * pow_of(128'(v), 4);
            lo = 0;
            hi = 4095;
            for (int s = 0; s < 13; s++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 1) / 2;
                    lhs = pow_of(128'(2 * mid - 1), 5) * pow_of(128'd255, 4);
                    if (lhs <= rhs) lo = mid;
                    else hi = mid - 1;
                end
            end
            t[v*LIN_W +: LIN_W] = LIN_W'(lo);
        end
        return t;
    endfunction

    // round(255*(128*i/4095)^1.25)
    function automatic logic [GAM_W*33-1:0] build_gam();
        logic [GAM_W*33-1:0] t;
        logic [127:0] rhs, lhs;
        int lo, hi, mid;
        t = '0;
        for (int v = 0; v <= 32; v++)
        begin
            rhs = 128'd16 * pow_of(128'd255, 4) * pow_of(128'(128 * v), 5);
            lo = 0;
            hi = 511;
            for (int s = 0; s < 10; s++)
            begin
                if (lo < hi)
                begin
                    mid = (lo + hi + 1) / 2;
                    lhs = pow_of(128'(2 * mid - 1), 4) * pow_of(128'd4095, 5);
                    if (lhs <= rhs) lo = mid;
                    else hi = mid - 1;
                end
            end
            t[v*GAM_W +: GAM_W] = GAM_W'(lo);
        end
        return t;
    endfunction

    localparam logic [LIN_W*256-1:0] LIN_ROM = build_lin();
    localparam logic [GAM_W*33-1:0]  GAM_ROM = build_gam();

    function automatic logic [LIN_W-1:0] lin_of(input logic [7:0] v);
        return LIN_ROM[v*LIN_W +: LIN_W];
    endfunction

    function automatic logic [GAM_W-1:0] gam_of(input logic [5:0] i);
        return GAM_ROM[i*GAM_W +: GAM_W];
    endfunction

endpackage

>>> rtl/core/ryuv_ctrl.sv
// ----------------------------------------------------------------------------
// ryuv_ctrl: conversion sequencer
// Steps one pixel through multiply, line-store read, averaging and output.
// ----------------------------------------------------------------------------
module ryuv_ctrl
    import ryuv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ryuv_stat_t stat,
    output ryuv_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL    = 7'b0000010,
        ST_RD1    = 7'b0000100,
        ST_RD2    = 7'b0001000,
        ST_LIN    = 7'b0010000,
        ST_INTERP = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [1:0]       comp_reg, comp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            comp_reg  <= comp_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        comp_next     = comp_reg;
        cmd           = '0;
        cmd.mul_idx   = idx_reg;
        cmd.comp      = comp_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    idx_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en   = 1'b1;
                cmd.cap_luma = (idx_reg == STEP_U_FIRST);
                cmd.cap_u    = (idx_reg == STEP_V_FIRST);
                idx_next     = idx_reg + 1'b1;
                if (idx_reg == STEP_LUMA_LAST)
                    state_next = stat.chroma ? ST_RD1 : ST_FIN;
                else if (idx_reg == STEP_LAST)
                    state_next = ST_FIN;
            end
            ST_RD1:
            begin
                cmd.tr_load = 1'b1;
                cmd.rd_prev = 1'b1;
                state_next  = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.tl_load = 1'b1;
                comp_next   = '0;
                state_next  = ST_LIN;
            end
            ST_LIN:
            begin
                cmd.lin_en = 1'b1;
                state_next = ST_INTERP;
            end
            ST_INTERP:
            begin
                cmd.interp_en = 1'b1;
                comp_next     = comp_reg + 1'b1;
                state_next    = (comp_reg == COMP_LAST) ? ST_MUL : ST_LIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/core/ryuv_dp.sv
// ----------------------------------------------------------------------------
// ryuv_dp: conversion datapath
// Position counters, line store, gamma or plain averaging, shared
// multiplier and output register.
// ----------------------------------------------------------------------------
module ryuv_dp
    import ryuv_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 16384
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFGD_W-1:0] cfg_data,
    input  logic [PIX_W-1:0]  s_tdata,
    input  ryuv_cmd_t         cmd,
    output ryuv_stat_t        stat,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [12:0]         width_reg;
    logic [14:0]         height_reg;
    logic                plain_reg;
    logic [CW-1:0]       col_reg, citem_reg;
    logic [RW-1:0]       row_reg;
    logic [PIX_W-1:0]    held_reg, cur_reg, bl_reg, tr_reg, tl_reg, rdata_reg;
    logic                rodd_reg, chroma_reg, last_reg;
    logic [PIX_W-1:0]    mem [MAX_WIDTH];
    logic [CW-1:0]       raddr;
    logic [13:0]         lin_sum_reg;
    logic [9:0]          plain_sum_reg;
    logic [SUM_W-1:0]    s_reg [3];
    logic signed [ACC_W-1:0] acc_reg;
    logic [7:0]          luma_reg, u_reg;
    logic                mvalid_reg;

    // Effective frame size
    logic [CMP_W-1:0] w_eff, h_eff;
    logic             last_col, last_row, codd, rodd;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = CMP_W'(1);
        else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = CMP_W'(width_reg);
        if (height_reg == '0)
            h_eff = CMP_W'(1);
        else if (CMP_W'(height_reg) > CMP_W'(MAX_HEIGHT))
            h_eff = CMP_W'(MAX_HEIGHT);
        else
            h_eff = CMP_W'(height_reg);
    end

    assign last_col = CMP_W'(col_reg) >= (w_eff - 1'b1);
    assign last_row = CMP_W'(row_reg) >= (h_eff - 1'b1);
    assign codd     = col_reg[0];
    assign rodd     = row_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 15'd1;
            plain_reg  <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            held_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_data[12:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    REG_PLAIN_MODE:   plain_reg  <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (cmd.accept)
            begin
                held_reg <= s_tdata;
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + 1'b1;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
            if (cmd.load_out)
                mvalid_reg <= 1'b1;
            else if (m_tready)
                mvalid_reg <= 1'b0;
        end
    end

    // Per-item capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cur_reg    <= s_tdata;
            bl_reg     <= codd ? held_reg : s_tdata;
            citem_reg  <= col_reg;
            rodd_reg   <= rodd;
            chroma_reg <= (codd || last_col) && (rodd || last_row);
            last_reg   <= last_col && last_row;
        end
    end

    // Line store: even rows written, odd rows read back
    assign raddr = cmd.rd_prev ? citem_reg - 1'b1 : citem_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !rodd)
            mem[col_reg] <= s_tdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tr_load)
            tr_reg <= rodd_reg ? rdata_reg : cur_reg;
        if (cmd.tl_load)
            tl_reg <= rodd_reg ? (citem_reg[0] ? rdata_reg : tr_reg) : bl_reg;
    end

    // Block averaging, one component per pass
    function automatic logic [7:0] pick(input logic [PIX_W-1:0] p, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = p[7:0];
            2'd1:    r = p[15:8];
            2'd2:    r = p[23:16];
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    logic [7:0]  ca, cb, cc, cd;
    logic [4:0]  pos;
    logic [8:0]  xf;
    logic [18:0] interp;

    assign ca = pick(tl_reg, cmd.comp);
    assign cb = pick(tr_reg, cmd.comp);
    assign cc = pick(bl_reg, cmd.comp);
    assign cd = pick(cur_reg, cmd.comp);
    assign pos = lin_sum_reg[13:9];
    assign xf  = lin_sum_reg[8:0];
    assign interp = 19'(gam_of({1'b0, pos} + 6'd1) * xf)
                  + 19'(gam_of({1'b0, pos}) * (10'd512 - {1'b0, xf})) + 19'd64;

    always_ff @(posedge clk)
    begin
        if (cmd.lin_en)
        begin
            lin_sum_reg   <= 14'(lin_of(ca)) + 14'(lin_of(cb))
                           + 14'(lin_of(cc)) + 14'(lin_of(cd));
            plain_sum_reg <= 10'(ca) + 10'(cb) + 10'(cc) + 10'(cd);
        end
        if (cmd.interp_en)
            s_reg[cmd.comp] <= plain_reg ? SUM_W'(plain_sum_reg) : interp[17:7];
    end

    // Shared multiplier and accumulator
    logic [SUM_W-1:0]         opnd;
    logic signed [ACC_W-1:0]  prod;
    logic                     first;
    logic signed [ACC_W-1:0]  ybias, cbias;
    logic [7:0]               luma_now, clip_now;

    always_comb
    begin
        case (cmd.mul_idx)
            4'd0:    opnd = SUM_W'(cur_reg[7:0]);
            4'd1:    opnd = SUM_W'(cur_reg[15:8]);
            4'd2:    opnd = SUM_W'(cur_reg[23:16]);
            4'd3:    opnd = s_reg[0];
            4'd4:    opnd = s_reg[1];
            4'd5:    opnd = s_reg[2];
            4'd6:    opnd = s_reg[0];
            4'd7:    opnd = s_reg[1];
            4'd8:    opnd = s_reg[2];
            default: opnd = '0;
        endcase
    end

    assign prod  = ACC_W'(coef_of(cmd.mul_idx) * $signed({1'b0, opnd}));
    assign first = (cmd.mul_idx == '0) || (cmd.mul_idx == STEP_U_FIRST)
                || (cmd.mul_idx == STEP_V_FIRST);

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            acc_reg <= (first ? '0 : acc_reg) + prod;
    end

    assign ybias    = acc_reg + ACC_W'(32768 + (16 << 16));
    assign luma_now = ybias[23:16];
    assign cbias    = acc_reg + ACC_W'((1 << 17) + (128 << 18));
    always_comb
    begin
        if (cbias < 0)
            clip_now = 8'd0;
        else if (cbias[ACC_W-2:18] > 255)
            clip_now = 8'd255;
        else
            clip_now = cbias[25:18];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_luma)
            luma_reg <= luma_now;
        if (cmd.cap_u)
            u_reg <= clip_now;
        if (cmd.load_out)
        begin
            m_tdata[7:0]   <= chroma_reg ? luma_reg : luma_now;
            m_tdata[15:8]  <= chroma_reg ? u_reg : 8'd0;
            m_tdata[23:16] <= chroma_reg ? clip_now : 8'd0;
            m_tuser        <= chroma_reg;
            m_tlast        <= last_reg;
        end
    end

    assign m_tvalid      = mvalid_reg;
    assign stat.chroma   = chroma_reg;
    assign stat.out_free = !mvalid_reg || m_tready;

endmodule

>>> rtl/core/rgb_to_yuv420_gamma_chroma_top.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_gamma_chroma_top: RGB to YUV 4:2:0 stream converter
// BT.601 limited-range luma per pixel, one gamma or plain averaged U/V per 2x2 block.
// ----------------------------------------------------------------------------
// Usage:
//   Feed pixels in raster order on the s_ channel (s_tdata: red, green, blue
//   from bit 0 up). Each input transaction yields exactly one output
//   transaction on the m_ channel: m_tdata carries luma, U, V (U and V are
//   zero unless m_tuser is set), m_tuser flags a pixel that completes a 2x2
//   block, m_tlast marks the last pixel of the frame.
//   Program image_width, image_height and plain_average_mode through the
//   cfg_ channel (cfg_index selects the register) while no pixel is in
//   flight; cfg_ready is always high.
// Timing:
//   One pixel is in work at a time. A pixel without chroma takes the three
//   luma products and goes to the output register; a chroma pixel adds two
//   line-store reads, an averaging pass (linearize, then interpolate) per
//   color component and six chroma products. The input takes the next pixel
//   only once the result is loaded into the output register. The time per
//   pixel is set by the single shared multiplier (3 or 9 products).
// Reset and stall:
//   Reset clears the position counters and the held pixel and loads width 1,
//   height 1, gamma mode. The line store is not cleared. If the receiver
//   stalls, the finished result waits in the output register while the next
//   pixel is accepted and computed; that pixel then waits for the register.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_gamma_chroma_top
    import ryuv_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 16384
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,    // [7:0] luma, [15:8] chroma_u, [23:16] chroma_v
    output logic              m_tuser,    // [0] chroma_valid
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFGD_W-1:0] cfg_data
);

    ryuv_cmd_t  cmd;
    ryuv_stat_t stat;

    // Register writes never stall
    assign cfg_ready = 1'b1;

    // Sequencer: owns the input handshake and steps each transaction
    ryuv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: counters, line store, averaging, multiplier, output register
    ryuv_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

>>> rtl/core/ryuv_chk.sv
// ----------------------------------------------------------------------------
// ryuv_chk: port-level checks
// Watches the converter's ports and flags behavior that breaks its contract.
// ----------------------------------------------------------------------------
module ryuv_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // Chroma fields stay zero without the block flag
    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[23:8] == 16'd0))
        else $error("chroma fields nonzero without chroma flag");

    // One pixel in work at a time: input closes after a transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a pixel is in work");

    // Luma stays in the limited range
    a_luma_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:0] >= 8'd16 && m_tdata[7:0] <= 8'd235))
        else $error("luma out of limited range");

    // A stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result dropped or changed");

endmodule

bind rgb_to_yuv420_gamma_chroma_top ryuv_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
